>>> rtl/ntis_pkg.sv
// Shared types and constants for the name table block.
// No dependencies; imported by every other rtl file.
`default_nettype none

package ntis_pkg;

    // defaults for the top level parameters
    localparam int CAPACITY_DEFAULT = 16;
    localparam int KEY_BITS_DEFAULT = 64;

    // fixed port widths
    localparam int PORT_KEY_BITS   = 64;
    localparam int PORT_INDEX_BITS = 4;
    localparam int PORT_COUNT_BITS = 5;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // request codes on req_type
    localparam logic [1:0] REQ_CREATE = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;
    localparam logic [1:0] REQ_LIST   = 2'd3;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_MOVE = 5'b00100,
        S_LIST = 5'b01000,
        S_OUT  = 5'b10000
    } back_state_t;

    // handshake between the command queue and its neighbors
    typedef struct packed {
        logic push;
        logic full;
        logic pop;
        logic avail;
    } q_ctl_t;

endpackage

`default_nettype wire

>>> rtl/ntis_front.sv
// Front end: takes request items, masks the key and decodes the request.
// Depends on ntis_pkg; feeds ntis_queue.
`default_nettype none

module ntis_front #(
    parameter int KEY_BITS = ntis_pkg::KEY_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [1:0]                        req_type,
    input  wire logic [ntis_pkg::PORT_KEY_BITS-1:0] file_key,
    input  wire logic                              q_full,
    output logic                                   q_push,
    output logic [KEY_BITS+1:0]                    q_data
);
    import ntis_pkg::*;

    logic                fv_reg, fv_next;
    op_t                 op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg;
    logic                accept;
    op_t                 dec_op;

    always_comb
    begin
        unique case (req_type)
            REQ_CREATE: dec_op = OP_CREATE;
            REQ_DELETE: dec_op = OP_DELETE;
            REQ_SEARCH: dec_op = OP_SEARCH;
            default:    dec_op = OP_LIST;
        endcase
    end

    assign in_stall = fv_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = fv_reg && !q_full;
    assign q_data   = {op_reg, key_reg};

    always_comb
    begin
        fv_next = fv_reg;
        op_next = op_reg;
        if (accept)
        begin
            fv_next = 1'b1;
            op_next = dec_op;
        end
        else if (q_push)
        begin
            fv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
            op_reg <= OP_CREATE;
        end
        else
        begin
            fv_reg <= fv_next;
            op_reg <= op_next;
        end
    end

    // only the low KEY_BITS of the key are kept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= file_key[KEY_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

>>> rtl/ntis_queue.sv
// Short command FIFO between the front end and the table engine.
// Depends on ntis_pkg for its depth.
`default_nettype none

module ntis_queue #(
    parameter int WIDTH = 66
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  avail,
    output logic [WIDTH-1:0]      pop_data
);
    import ntis_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slots [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full     = (fill_reg == CW'(QUEUE_DEPTH));
    assign avail    = (fill_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && avail;
    assign pop_data = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ntis_back.sv
// Table engine: key memory, entry count and the sequencer that walks it.
// Depends on ntis_pkg; pops commands from ntis_queue, drives the result item.
`default_nettype none

module ntis_back #(
    parameter int CAPACITY = ntis_pkg::CAPACITY_DEFAULT,
    parameter int KEY_BITS = ntis_pkg::KEY_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                q_avail,
    input  wire logic [KEY_BITS+1:0]                 q_data,
    output logic                                     q_pop,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [1:0]                               status,
    output logic [ntis_pkg::PORT_KEY_BITS-1:0]       entry_key,
    output logic [ntis_pkg::PORT_INDEX_BITS-1:0]     entry_index,
    output logic [ntis_pkg::PORT_COUNT_BITS-1:0]     entry_count,
    output logic                                     last
);
    import ntis_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [KEY_BITS-1:0] mem [CAPACITY];
    logic [KEY_BITS-1:0] rd_data_reg;
    logic [IW-1:0]       raddr, waddr;
    logic                we;
    logic [KEY_BITS-1:0] wdata;

    back_state_t         state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                more_reg, more_next;

    logic                         out_valid_reg, out_valid_next;
    status_t                      status_reg, status_next;
    logic [PORT_KEY_BITS-1:0]     okey_reg, okey_next;
    logic [PORT_INDEX_BITS-1:0]   oidx_reg, oidx_next;
    logic [PORT_COUNT_BITS-1:0]   ocount_reg, ocount_next;
    logic                         last_reg, last_next;

    // result being loaded this cycle
    logic                load;
    status_t             res_status;
    logic [KEY_BITS-1:0] res_key;
    logic [IW-1:0]       res_idx;
    logic [CW-1:0]       res_count;
    logic                res_last, res_more;
    logic [IW+3:0]       res_idx_wide;
    logic [CW+4:0]       res_count_wide;

    op_t                 q_op;
    logic [KEY_BITS-1:0] q_key;
    logic [IW-1:0]       idx_inc;
    logic [CW-1:0]       last_slot;
    logic                at_end, match;

    assign q_op      = op_t'(q_data[KEY_BITS+1:KEY_BITS]);
    assign q_key     = q_data[KEY_BITS-1:0];
    assign idx_inc   = idx_reg + IW'(1);
    assign last_slot = count_reg - CW'(1);
    assign at_end    = (CW'(idx_reg) + CW'(1) == count_reg);
    assign match     = (rd_data_reg == key_reg);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        more_next  = more_reg;
        q_pop      = 1'b0;
        raddr      = idx_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = key_reg;
        load       = 1'b0;
        res_status = ST_OK;
        res_key    = '0;
        res_idx    = '0;
        res_count  = count_reg;
        res_last   = 1'b1;
        res_more   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_avail)
                begin
                    q_pop    = 1'b1;
                    op_next  = q_op;
                    key_next = q_key;
                    idx_next = '0;
                    raddr    = '0;
                    unique case (q_op)
                        OP_CREATE:
                        begin
                            load = 1'b1;
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = count_reg[IW-1:0];
                                wdata      = q_key;
                                count_next = count_reg + CW'(1);
                                res_idx    = count_reg[IW-1:0];
                                res_count  = count_reg + CW'(1);
                            end
                        end
                        OP_DELETE, OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                load       = 1'b1;
                                res_status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                load       = 1'b1;
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_LIST;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // rd_data_reg holds mem[idx_reg]
                priority if (match && op_reg == OP_DELETE)
                begin
                    raddr      = last_slot[IW-1:0];
                    state_next = S_MOVE;
                end
                else if (match)
                begin
                    load    = 1'b1;
                    res_idx = idx_reg;
                end
                else if (at_end)
                begin
                    load       = 1'b1;
                    res_status = ST_NOT_FOUND;
                end
                else
                begin
                    idx_next = idx_inc;
                    raddr    = idx_inc;
                end
            end
            S_MOVE:
            begin
                // last entry fills the hole; deleting the last one moves it onto itself
                we         = 1'b1;
                waddr      = idx_reg;
                wdata      = rd_data_reg;
                count_next = last_slot;
                load       = 1'b1;
                res_idx    = idx_reg;
                res_count  = last_slot;
            end
            S_LIST:
            begin
                load     = 1'b1;
                res_key  = rd_data_reg;
                res_idx  = idx_reg;
                res_last = at_end;
                res_more = !at_end;
            end
            default:
            begin
                if (!out_stall)
                begin
                    if (more_reg)
                    begin
                        idx_next   = idx_inc;
                        raddr      = idx_inc;
                        state_next = S_LIST;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
        endcase

        if (load)
        begin
            more_next  = res_more;
            state_next = S_OUT;
        end
    end

    assign res_idx_wide   = (IW + 4)'(res_idx);
    assign res_count_wide = (CW + 5)'(res_count);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        okey_next      = okey_reg;
        oidx_next      = oidx_reg;
        ocount_next    = ocount_reg;
        last_next      = last_reg;
        if (state_reg == S_OUT && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            status_next    = res_status;
            okey_next      = PORT_KEY_BITS'(res_key);
            oidx_next      = res_idx_wide[PORT_INDEX_BITS-1:0];
            ocount_next    = res_count_wide[PORT_COUNT_BITS-1:0];
            last_next      = res_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            more_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            more_reg      <= more_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        okey_reg   <= okey_next;
        oidx_reg   <= oidx_next;
        ocount_reg <= ocount_next;
        last_reg   <= last_next;
    end

    // single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_key   = okey_reg;
    assign entry_index = oidx_reg;
    assign entry_count = ocount_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg == (state_reg == S_OUT))
        else $error("result valid outside output state");

    a_create_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && q_avail && q_op == OP_CREATE && count_reg < CW'(CAPACITY))
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("create did not grow the table");

    a_move_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MOVE |=> count_reg == $past(count_reg) - CW'(1))
        else $error("delete did not shrink the table");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_LIST) |-> CW'(idx_reg) < count_reg)
        else $error("walk past the stored entries");
`endif

endmodule

`default_nettype wire

>>> rtl/name_table_insert_delete_search.sv
// Top level of the name table: front end, command queue and table engine.
// Depends on ntis_pkg, ntis_front, ntis_queue and ntis_back.
//
//  channel   handshake             payload
//  request   in_valid / in_stall   req_type, file_key
//  result    out_valid / out_stall status, entry_key, entry_index, entry_count, last
//
// Create gives its result once the request item has passed the front register, a
// queue slot and the result register; search and delete compare one stored key per
// cycle through the key memory's single read port; delete then moves the last entry
// into the hole. List gives one result per entry, advancing while out_stall is low.
// Reset clears the count and all handshake state; the key memory is not cleared.
// Up to three requests are buffered ahead of the engine while a result is stalled.
`default_nettype none

module name_table_insert_delete_search #(
    parameter int CAPACITY = ntis_pkg::CAPACITY_DEFAULT,
    parameter int KEY_BITS = ntis_pkg::KEY_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [1:0]                          req_type,
    input  wire logic [ntis_pkg::PORT_KEY_BITS-1:0]  file_key,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [1:0]                               status,
    output logic [ntis_pkg::PORT_KEY_BITS-1:0]       entry_key,
    output logic [ntis_pkg::PORT_INDEX_BITS-1:0]     entry_index,
    output logic [ntis_pkg::PORT_COUNT_BITS-1:0]     entry_count,
    output logic                                     last
);
    import ntis_pkg::*;

    q_ctl_t              qc;
    logic [KEY_BITS+1:0] push_data;
    logic [KEY_BITS+1:0] pop_data;

    ntis_front #(
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .file_key (file_key),
        .q_full   (qc.full),
        .q_push   (qc.push),
        .q_data   (push_data)
    );

    ntis_queue #(
        .WIDTH (KEY_BITS + 2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (qc.push),
        .push_data (push_data),
        .full      (qc.full),
        .pop       (qc.pop),
        .avail     (qc.avail),
        .pop_data  (pop_data)
    );

    ntis_back #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_avail     (qc.avail),
        .q_data      (pop_data),
        .q_pop       (qc.pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .entry_key   (entry_key),
        .entry_index (entry_index),
        .entry_count (entry_count),
        .last        (last)
    );

endmodule

`default_nettype wire
